/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tcpp_pkg.sv */
// Types and constants of the text command protocol parser.
package tcpp_pkg;

    localparam int TOK_LEN_W = 8;
    localparam int KW_COUNT = 10;
    localparam int KW_FIRST_FIELD = 5;
    localparam int KW_HASH = 9;

    // Input cmd codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Command codes
    localparam logic [2:0] CC_GET    = 3'd0;
    localparam logic [2:0] CC_PUT    = 3'd1;
    localparam logic [2:0] CC_NONE   = 3'd7;

    // Field kinds
    localparam logic [1:0] FK_PASSWORD = 2'd0;
    localparam logic [1:0] FK_FILENAME = 2'd1;
    localparam logic [1:0] FK_FILESIZE = 2'd2;
    localparam logic [1:0] FK_MODE     = 2'd3;

    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";

    // Keyword spelling, padded with zeros; commands, fields, then '#'
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"L", "I", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"V", "E", "R", "I", "F", "Y", 8'h00, 8'h00},
        '{"R", "E", "B", "O", "O", "T", 8'h00, 8'h00},
        '{"p", "a", "s", "s", "w", "o", "r", "d"},
        '{"f", "i", "l", "e", "n", "a", "m", "e"},
        '{"f", "i", "l", "e", "s", "i", "z", "e"},
        '{"m", "o", "d", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"#", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd3, 4'd4, 4'd6, 4'd6, 4'd8, 4'd8, 4'd8, 4'd4, 4'd1
    };

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_INIT    = 3'd1,
        PH_FIELD   = 3'd2,
        PH_VALUE   = 3'd3,
        PH_COMMAND = 3'd4,
        PH_CLOSING = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_START      = 3'd1,
        EV_NAME_BYTE  = 3'd2,
        EV_NAME_END   = 3'd3,
        EV_PUT_BYTE   = 3'd4,
        EV_PUT_DONE   = 3'd5,
        EV_CLOSE_REQ  = 3'd6,
        EV_CLOSE_FILE = 3'd7
    } ev_t;

    typedef enum logic [1:0] {
        TOK_SKIP   = 2'd0,
        TOK_APPEND = 2'd1,
        TOK_END    = 2'd2,
        TOK_FULL   = 2'd3
    } tok_res_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       packet_end;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  code;
        logic [31:0] value;
        logic [7:0]  out_byte;
    } out_beat_t;

    typedef struct packed {
        logic [TOK_LEN_W-1:0] len;
        logic [KW_COUNT-1:0]  match;
        logic [31:0]          accum;
        logic                 neg;
        logic                 stopped;
    } tok_state_t;

    typedef struct packed {
        tok_res_t            res;
        tok_state_t          st;
        logic [KW_COUNT-1:0] hit;
    } tok_out_t;

    localparam tok_state_t TOK_CLEAR = '{
        len: '0, match: '1, accum: '0, neg: 1'b0, stopped: 1'b0
    };

endpackage

/* rtl/tcpp_token.sv */
// Tokenizer step: keyword match, decimal accumulate and token end detection.
module tcpp_token import tcpp_pkg::*; #(
    parameter int MAX_TOKEN = 251
) (
    input  tok_state_t  st,
    input  logic [7:0]  data_byte,
    output tok_out_t    tok
);

    logic       is_ctrl;
    logic       is_digit;
    tok_state_t app;
    logic [TOK_LEN_W-1:0] len_app;

    assign is_ctrl  = data_byte < CTRL_LIMIT;
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign len_app  = st.len + TOK_LEN_W'(1);

    always_comb begin
        app = st;
        app.len = len_app;
        for (int k = 0; k < KW_COUNT; k++) begin
            if ((st.len >= TOK_LEN_W'(KW_LEN[k])) || (KW_TEXT[k][st.len[2:0]] != data_byte)) begin
                app.match[k] = 1'b0;
            end
        end
        if ((st.len == '0) && (data_byte == CH_MINUS)) begin
            app.neg = 1'b1;
        end else if (!st.stopped) begin
            if (is_digit) begin
                // x*10 as two shifts and an add, wrapping at 32 bits
                app.accum = (st.accum << 3) + (st.accum << 1)
                          + {24'd0, data_byte - CH_ZERO};
            end else begin
                app.stopped = 1'b1;
            end
        end
    end

    always_comb begin
        if (is_ctrl) begin
            tok.res = (st.len == '0) ? TOK_SKIP : TOK_END;
            tok.st  = st;
        end else begin
            tok.res = (len_app >= TOK_LEN_W'(MAX_TOKEN)) ? TOK_FULL : TOK_APPEND;
            tok.st  = app;
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            tok.hit[k] = tok.st.match[k] && (tok.st.len == TOK_LEN_W'(KW_LEN[k]));
        end
    end

endmodule

/* rtl/tcpp_skid.sv */
// Output register with one skid entry for the result channel.
module tcpp_skid import tcpp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  out_beat_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_beat_t out_reg, out_next;
    out_beat_t skid_reg, skid_next;
    logic      take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign take      = in_valid && !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready) begin
            // skid entry drains first; no new beat is taken while it is full
            out_valid_next  = skid_valid_reg || take;
            out_next        = skid_valid_reg ? skid_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (take) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/text_command_protocol_parser.sv */
// Top level of the text command protocol parser.
//
// Usage:
//   s_ channel: one beat per event - a received byte (cmd 0), connection
//   opened (cmd 1) or connection closed (cmd 2), with packet_end on the
//   last byte of a delivered packet. cmd 3 is ignored.
//   m_ channel: exactly one result beat per input beat, in order. Most are
//   event_res 0 (none); the others carry command start, filename bytes and
//   name end, PUT data bytes, PUT completion, close requests or file close.
//   Result: registered in the output register, or in the skid while stalled.
//   Throughput: one beat per cycle while s_ready is high; all per-byte
//   work (keyword compare, decimal accumulate, size compare) fits between
//   the state registers and the output register.
//   Stall: a one-entry skid behind the output register lets one more beat
//   in while m_ready is low; then s_ready drops until the skid drains.
//   Reset: parser idle, no command, counters cleared, m_valid low.
//   A byte while idle gives a close request.
module text_command_protocol_parser import tcpp_pkg::*; #(
    parameter int MAX_TOKEN = 251
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // ---------------- parser state ----------------
    phase_t     phase_reg, phase_next;
    logic [2:0] cmd_code_reg, cmd_code_next;
    logic [1:0] field_kind_reg, field_kind_next;
    tok_state_t tok_reg, tok_next;
    logic [31:0] size_limit_reg, size_limit_next;
    logic [31:0] bytes_taken_reg, bytes_taken_next;
    logic       skip_reg, skip_next;
    logic       put_done_reg, put_done_next;

    logic       accept;
    tok_out_t   tok;
    logic       ended;
    logic       cmd_hit;
    logic [2:0] cmd_hit_code;
    logic       field_hit;
    logic [1:0] field_hit_kind;
    logic       is_ctrl;
    logic       took;
    logic [31:0] bt_inc;
    out_beat_t  beat;

    assign accept  = s_valid && s_ready;
    assign is_ctrl = s_data.data_byte < CTRL_LIMIT;
    assign ended   = (tok.res == TOK_END) || (tok.res == TOK_FULL);
    assign bt_inc  = bytes_taken_reg + 32'd1;
    assign took    = bytes_taken_reg < size_limit_reg;

    // one byte step of the current token
    tcpp_token #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_token (
        .st        (tok_reg),
        .data_byte (s_data.data_byte),
        .tok       (tok)
    );

    // keyword hits: command words, then field names; later entry wins
    always_comb begin
        cmd_hit        = 1'b0;
        cmd_hit_code   = CC_GET;
        field_hit      = 1'b0;
        field_hit_kind = FK_PASSWORD;
        for (int k = 0; k < KW_FIRST_FIELD; k++) begin
            if (tok.hit[k]) begin
                cmd_hit      = 1'b1;
                cmd_hit_code = 3'(k);
            end
        end
        for (int k = KW_FIRST_FIELD; k < KW_HASH; k++) begin
            if (tok.hit[k]) begin
                field_hit      = 1'b1;
                field_hit_kind = 2'(k - KW_FIRST_FIELD);
            end
        end
    end

    // ---------------- next phase ----------------
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (s_data.cmd)
                CMD_OPEN:  phase_next = PH_INIT;
                CMD_CLOSE: phase_next = PH_IDLE;
                CMD_BYTE: begin
                    unique case (phase_reg)
                        PH_INIT: begin
                            if (ended) begin
                                phase_next = cmd_hit ? PH_FIELD : PH_CLOSING;
                            end
                        end
                        PH_FIELD: begin
                            if (ended) begin
                                if (field_hit) begin
                                    phase_next = PH_VALUE;
                                end else if (tok.hit[KW_HASH]) begin
                                    phase_next = PH_COMMAND;
                                end else begin
                                    phase_next = PH_CLOSING;
                                end
                            end
                        end
                        PH_VALUE: begin
                            if (ended) begin
                                phase_next = PH_FIELD;
                            end
                        end
                        PH_COMMAND, PH_CLOSING: phase_next = phase_reg;
                        default: phase_next = PH_CLOSING;
                    endcase
                    // closing ends with the packet
                    if (s_data.packet_end && (phase_next == PH_CLOSING)) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // ---------------- datapath and result beat ----------------
    always_comb begin
        cmd_code_next    = cmd_code_reg;
        field_kind_next  = field_kind_reg;
        tok_next         = tok_reg;
        size_limit_next  = size_limit_reg;
        bytes_taken_next = bytes_taken_reg;
        skip_next        = skip_reg;
        put_done_next    = put_done_reg;
        beat             = '0;
        if (accept) begin
            case (s_data.cmd)
                CMD_OPEN: begin
                    cmd_code_next    = CC_NONE;
                    tok_next         = TOK_CLEAR;
                    size_limit_next  = '0;
                    bytes_taken_next = '0;
                    skip_next        = 1'b0;
                    put_done_next    = 1'b0;
                end
                CMD_CLOSE: begin
                    if ((cmd_code_reg == CC_GET) || (cmd_code_reg == CC_PUT)) begin
                        beat.event_res = EV_CLOSE_FILE;
                    end
                end
                CMD_BYTE: begin
                    case (phase_reg)
                        PH_INIT, PH_FIELD, PH_VALUE: begin
                            // token bytes: a control ending a token arms the skip
                            if (tok.res == TOK_END) begin
                                skip_next = 1'b1;
                            end else if (tok.res != TOK_SKIP) begin
                                skip_next = 1'b0;
                            end
                            tok_next = ended ? TOK_CLEAR : tok.st;
                            if (phase_reg == PH_INIT) begin
                                if (ended) begin
                                    if (cmd_hit) begin
                                        cmd_code_next = cmd_hit_code;
                                    end else begin
                                        beat.event_res = EV_CLOSE_REQ;
                                    end
                                end
                            end else if (phase_reg == PH_FIELD) begin
                                if (ended) begin
                                    if (field_hit) begin
                                        field_kind_next = field_hit_kind;
                                    end else if (tok.hit[KW_HASH]) begin
                                        beat.event_res = EV_START;
                                        beat.code      = cmd_code_reg;
                                        beat.value     = size_limit_reg;
                                    end else begin
                                        beat.event_res = EV_CLOSE_REQ;
                                    end
                                end
                            end else begin
                                if (field_kind_reg == FK_FILENAME) begin
                                    case (tok.res)
                                        TOK_APPEND: begin
                                            beat.event_res = EV_NAME_BYTE;
                                            beat.value     = {24'd0, tok_reg.len};
                                            beat.out_byte  = s_data.data_byte;
                                        end
                                        TOK_FULL: begin
                                            beat.event_res = EV_NAME_END;
                                            beat.value     = {24'd0, tok.st.len};
                                            beat.out_byte  = s_data.data_byte;
                                        end
                                        TOK_END: begin
                                            beat.event_res = EV_NAME_END;
                                            beat.value     = {24'd0, tok.st.len};
                                        end
                                        default: beat.event_res = EV_NONE;
                                    endcase
                                end
                                if (ended && ((field_kind_reg == FK_FILESIZE)
                                              || (field_kind_reg == FK_MODE))) begin
                                    size_limit_next  = tok.st.neg ? (32'd0 - tok.st.accum)
                                                                  : tok.st.accum;
                                    bytes_taken_next = '0;
                                end
                            end
                        end
                        PH_COMMAND: begin
                            if ((cmd_code_reg == CC_PUT) && !put_done_reg
                                && !(skip_reg && is_ctrl)) begin
                                skip_next = 1'b0;
                                if (took) begin
                                    bytes_taken_next = bt_inc;
                                end
                                // size reached at packet end: complete once
                                if (s_data.packet_end && (!took || (bt_inc == size_limit_reg))) begin
                                    beat.event_res = EV_PUT_DONE;
                                    put_done_next  = 1'b1;
                                    beat.value     = {31'd0, took};
                                    beat.out_byte  = took ? s_data.data_byte : 8'd0;
                                end else if (took) begin
                                    beat.event_res = EV_PUT_BYTE;
                                    beat.value     = bytes_taken_reg;
                                    beat.out_byte  = s_data.data_byte;
                                end
                            end
                        end
                        PH_CLOSING: beat.event_res = EV_NONE;
                        default:    beat.event_res = EV_CLOSE_REQ;
                    endcase
                    if (s_data.packet_end) begin
                        skip_next = 1'b0;
                    end
                end
                default: beat.event_res = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            cmd_code_reg    <= CC_NONE;
            field_kind_reg  <= FK_PASSWORD;
            tok_reg         <= TOK_CLEAR;
            size_limit_reg  <= '0;
            bytes_taken_reg <= '0;
            skip_reg        <= 1'b0;
            put_done_reg    <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            cmd_code_reg    <= cmd_code_next;
            field_kind_reg  <= field_kind_next;
            tok_reg         <= tok_next;
            size_limit_reg  <= size_limit_next;
            bytes_taken_reg <= bytes_taken_next;
            skip_reg        <= skip_next;
            put_done_reg    <= put_done_next;
        end
    end

    // result beat into the output register / skid
    tcpp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (beat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

/* rtl/tcpp_checker.sv */
// Port-level checks of the parser, bound to its top level.
`include "assert_macros.svh"

module tcpp_checker import tcpp_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    `ASSERT_CLK(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")
    `ASSERT_CLK(a_code_only_start, aclk, aresetn, m_valid && (m_data.event_res != EV_START) |-> m_data.code == 3'd0, "code set outside command start")
    `ASSERT_CLK(a_quiet_fields, aclk, aresetn, m_valid && (m_data.event_res == EV_NONE || m_data.event_res == EV_CLOSE_REQ || m_data.event_res == EV_CLOSE_FILE) |-> m_data.value == 32'd0 && m_data.out_byte == 8'd0, "payload set on a bare event")
    `ASSERT_CLK(a_stall_only_full, aclk, aresetn, !s_ready |-> m_valid, "input stalled with no result pending")

endmodule

bind text_command_protocol_parser tcpp_checker u_tcpp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* bench/text_command_protocol_parser_tb.sv */
// Self-checking testbench for the text command protocol parser.
module text_command_protocol_parser_tb;
    import tcpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Same token limit as the block's default.
    localparam int MAX_TOK = 251;
    // Number of random beats, and the point after which idling stops.
    localparam int RANDOM_BEATS = 1500;
    localparam int QUIET_FROM = 1250;
    // Cycles in a row with no beat moving on either side before giving up.
    localparam int STALL_LIMIT = 1000;
    // Idle cycles run after the results drain, before the final check.
    localparam int TAIL_CYCLES = 8;
    // cmd code with no meaning; the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    text_command_protocol_parser #(
        .MAX_TOKEN(MAX_TOK)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Parser model: token splitter, keyword matcher, decimal accumulator
    // and PUT byte counter, kept in step with every accepted input beat.
    // ------------------------------------------------------------------
    // Keyword list: five commands, four field names, then the start mark.
    string kw_word [KW_COUNT] = '{
        "GET", "PUT", "LIST", "VERIFY", "REBOOT",
        "password", "filename", "filesize", "mode", "#"
    };

    phase_t      pr_phase;
    logic [2:0]  pr_cmd;
    logic [1:0]  pr_field;
    int unsigned tk_len;
    logic [KW_COUNT-1:0] tk_match;
    logic [31:0] tk_num;
    bit          tk_neg;
    bit          tk_stop;
    logic [31:0] size_lim;
    logic [31:0] taken;
    bit          skip_ctl;
    bit          put_done;

    function automatic void clear_token();
        tk_len   = 0;
        tk_match = '1;
        tk_num   = '0;
        tk_neg   = 1'b0;
        tk_stop  = 1'b0;
    endfunction

    function automatic void reset_parser_model();
        pr_phase = PH_IDLE;
        pr_cmd   = CC_NONE;
        pr_field = FK_PASSWORD;
        clear_token();
        size_lim = '0;
        taken    = '0;
        skip_ctl = 1'b0;
        put_done = 1'b0;
    endfunction

    function automatic bit keyword_done(int k);
        return tk_match[k] && (kw_word[k].len() == tk_len);
    endfunction

    // Feed one byte to the token splitter.
    function automatic tok_res_t take_token_byte(logic [7:0] b);
        int unsigned pos;
        pos = tk_len;
        if (b < CTRL_LIMIT) begin
            if (tk_len == 0) return TOK_SKIP;
            skip_ctl = 1'b1;
            return TOK_END;
        end
        skip_ctl = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos >= kw_word[k].len() || kw_word[k][pos] != b) tk_match[k] = 1'b0;
        end
        if (pos == 0 && b == CH_MINUS) begin
            tk_neg = 1'b1;
        end else if (!tk_stop) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                tk_num = tk_num * 32'd10 + 32'(b - CH_ZERO);
            end else begin
                tk_stop = 1'b1;
            end
        end
        tk_len = pos + 1;
        return (tk_len >= MAX_TOK) ? TOK_FULL : TOK_APPEND;
    endfunction

    function automatic out_beat_t predict_parser_event(in_beat_t t);
        out_beat_t   r;
        tok_res_t    tr;
        int          hit;
        int unsigned pos;
        bit          took;
        r = '0;
        case (t.cmd)
            CMD_OPEN: begin
                pr_phase = PH_INIT;
                pr_cmd   = CC_NONE;
                clear_token();
                size_lim = '0;
                taken    = '0;
                skip_ctl = 1'b0;
                put_done = 1'b0;
            end
            CMD_CLOSE: begin
                if (pr_cmd == CC_GET || pr_cmd == CC_PUT) r.event_res = EV_CLOSE_FILE;
                pr_phase = PH_IDLE;
            end
            CMD_BYTE: begin
                case (pr_phase)
                    PH_INIT: begin
                        tr = take_token_byte(t.data_byte);
                        if (tr >= TOK_END) begin
                            hit = -1;
                            for (int k = 0; k < KW_FIRST_FIELD; k++) begin
                                if (keyword_done(k)) hit = k;
                            end
                            if (hit >= 0) begin
                                pr_cmd   = 3'(hit);
                                pr_phase = PH_FIELD;
                            end else begin
                                r.event_res = EV_CLOSE_REQ;
                                pr_phase    = PH_CLOSING;
                            end
                            clear_token();
                        end
                    end
                    PH_FIELD: begin
                        tr = take_token_byte(t.data_byte);
                        if (tr >= TOK_END) begin
                            hit = -1;
                            for (int k = KW_FIRST_FIELD; k < KW_HASH; k++) begin
                                if (keyword_done(k)) hit = k;
                            end
                            if (hit >= 0) begin
                                pr_field = 2'(hit - KW_FIRST_FIELD);
                                pr_phase = PH_VALUE;
                            end else if (keyword_done(KW_HASH)) begin
                                pr_phase    = PH_COMMAND;
                                r.event_res = EV_START;
                                r.code      = pr_cmd;
                                r.value     = size_lim;
                            end else begin
                                r.event_res = EV_CLOSE_REQ;
                                pr_phase    = PH_CLOSING;
                            end
                            clear_token();
                        end
                    end
                    PH_VALUE: begin
                        pos = tk_len;
                        tr  = take_token_byte(t.data_byte);
                        if (pr_field == FK_FILENAME) begin
                            // name bytes stream out; the limit byte comes with the end
                            case (tr)
                                TOK_APPEND: begin
                                    r.event_res = EV_NAME_BYTE;
                                    r.value     = pos;
                                    r.out_byte  = t.data_byte;
                                end
                                TOK_FULL: begin
                                    r.event_res = EV_NAME_END;
                                    r.value     = tk_len;
                                    r.out_byte  = t.data_byte;
                                end
                                TOK_END: begin
                                    r.event_res = EV_NAME_END;
                                    r.value     = tk_len;
                                end
                                default: ;
                            endcase
                        end
                        if (tr >= TOK_END) begin
                            // mode updates the size too
                            if (pr_field == FK_FILESIZE || pr_field == FK_MODE) begin
                                size_lim = tk_neg ? (32'd0 - tk_num) : tk_num;
                                taken    = '0;
                            end
                            pr_phase = PH_FIELD;
                            clear_token();
                        end
                    end
                    PH_COMMAND: begin
                        if (pr_cmd == CC_PUT && !put_done
                                && !(skip_ctl && t.data_byte < CTRL_LIMIT)) begin
                            skip_ctl = 1'b0;
                            took     = 1'b0;
                            pos      = taken;
                            if (taken < size_lim) begin
                                taken = taken + 1;
                                took  = 1'b1;
                            end
                            if (t.packet_end && taken >= size_lim) begin
                                r.event_res = EV_PUT_DONE;
                                put_done    = 1'b1;
                                r.value     = took ? 32'd1 : 32'd0;
                                r.out_byte  = took ? t.data_byte : 8'd0;
                            end else if (took) begin
                                r.event_res = EV_PUT_BYTE;
                                r.value     = pos;
                                r.out_byte  = t.data_byte;
                            end
                        end
                    end
                    PH_CLOSING: ;
                    default: begin
                        // byte with no connection open
                        r.event_res = EV_CLOSE_REQ;
                        pr_phase    = PH_CLOSING;
                    end
                endcase
                if (t.packet_end) begin
                    skip_ctl = 1'b0;
                    if (pr_phase == PH_CLOSING) pr_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predictions are queued when an input beat is taken and
    // popped when a result beat is taken. Both sides are sampled at the
    // same rising edge, before any of this edge's updates land.
    // ------------------------------------------------------------------
    out_beat_t pending_events [$];
    int        mismatch_count  = 0;
    int        results_checked = 0;
    int        stuck_cycles    = 0;

    // Side-band that travels with each beat: a typed-in result overrides
    // the model's prediction for that row.
    bit        row_typed  = 1'b0;
    out_beat_t row_result = '0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s at result %0d: got 0x%0h, want 0x%0h",
                 what, results_checked, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : scoreboard
        out_beat_t want;
        bit        moved;
        if (!aresetn) begin
            reset_parser_model();
            stuck_cycles <= 0;
        end else begin
            moved = 1'b0;
            if (m_valid === 1'b1 && m_ready) begin
                moved = 1'b1;
                if (pending_events.size() == 0) begin
                    report_mismatch("beat with nothing pending", m_data.event_res, '0);
                end else begin
                    want = pending_events.pop_front();
                    if (m_data.event_res !== want.event_res)
                        report_mismatch("event_res", m_data.event_res, want.event_res);
                    if (m_data.code !== want.code)
                        report_mismatch("code", m_data.code, want.code);
                    if (m_data.value !== want.value)
                        report_mismatch("value", m_data.value, want.value);
                    if (m_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", m_data.out_byte, want.out_byte);
                end
                results_checked++;
            end
            if (s_valid && s_ready === 1'b1) begin
                moved = 1'b1;
                // model always runs so its state tracks the table rows too
                want = predict_parser_event(s_data);
                if (row_typed) want = row_result;
                pending_events.push_back(want);
            end
            stuck_cycles <= moved ? 0 : stuck_cycles + 1;
        end
    end

    // Watchdog on forward progress.
    initial begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: m_ready drops in random bursts.
    // ------------------------------------------------------------------
    bit rx_stalls_on = 1'b1;
    bit quiet_tail   = 1'b0;
    int stall_left   = 0;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stalls_on && !quiet_tail && $urandom_range(0, 11) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------
    bit       tx_gaps_on = 1'b1;
    int       beats_sent = 0;
    in_beat_t script_q [$];

    function automatic in_beat_t beat(logic [1:0] c, logic [7:0] b, logic p);
        in_beat_t t;
        t.cmd        = c;
        t.data_byte  = b;
        t.packet_end = p;
        return t;
    endfunction

    function automatic out_beat_t event_of(ev_t e, logic [2:0] c);
        out_beat_t r;
        r           = '0;
        r.event_res = e;
        r.code      = c;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(in_beat_t b, bit typed, out_beat_t res);
        if (tx_gaps_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_data     <= b;
        s_valid    <= 1'b1;
        row_typed  <= typed;
        row_result <= res;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        beats_sent++;
    endtask

    // Hold off until every queued result has come back. The first edge
    // lets the scoreboard record the last beat taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    function automatic void queue_byte(logic [7:0] b, logic p);
        script_q.push_back(beat(CMD_BYTE, b, p));
    endfunction

    // Text bytes, with an occasional packet boundary in the middle.
    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], $urandom_range(0, 15) == 0);
    endfunction

    // 1..3 control bytes; the first ends the token, the rest get skipped.
    function automatic void queue_token_end();
        repeat ($urandom_range(1, 3))
            queue_byte(8'($urandom_range(0, 31)), $urandom_range(0, 9) == 0);
    endfunction

    // Free text value; now and then long enough to run into the token limit.
    function automatic void queue_free_text();
        int n;
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(MAX_TOK - 6, MAX_TOK + 8)
                                         : $urandom_range(1, 10);
        repeat (n) queue_byte(8'($urandom_range(32, 255)), $urandom_range(0, 15) == 0);
    endfunction

    function automatic string number_text();
        case ($urandom_range(0, 9))
            0: return $sformatf("-%0d", $urandom_range(0, 99));
            1: return $sformatf("%0d", {$urandom, $urandom});      // wraps past 2^32
            2: return $sformatf("%0dq%0d", $urandom_range(0, 999), $urandom_range(0, 9));
            3: return "-";
            4: return $sformatf("%0d", $urandom);
            default: return $sformatf("%0d", $urandom_range(0, 24));
        endcase
    endfunction

    // Now and then corrupt one character so the keyword may no longer match.
    function automatic string maybe_break(string w, int odds);
        string s;
        s = w;
        if ($urandom_range(0, odds - 1) == 0)
            s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(33, 126)));
        return s;
    endfunction

    // One connection: open, command word, fields, usually '#', data packets, usually close.
    function automatic void queue_session();
        int k;
        int fk;
        script_q.push_back(beat(CMD_OPEN, 8'($urandom), 1'($urandom)));
        k = $urandom_range(0, KW_FIRST_FIELD - 1);
        queue_text(maybe_break(kw_word[k], 12));
        queue_token_end();
        repeat ($urandom_range(0, 4)) begin
            fk = $urandom_range(0, 3);
            queue_text(maybe_break(kw_word[KW_FIRST_FIELD + fk], 25));
            queue_token_end();
            if (fk == FK_FILESIZE || fk == FK_MODE) queue_text(number_text());
            else queue_free_text();
            queue_token_end();
        end
        // PUT usually gets a small size so completion is reached
        if (k == CC_PUT && $urandom_range(0, 4) != 0) begin
            queue_text(kw_word[KW_FIRST_FIELD + FK_FILESIZE]);
            queue_token_end();
            queue_text($sformatf("%0d", $urandom_range(0, 24)));
            queue_token_end();
        end
        if ($urandom_range(0, 14) != 0) begin
            queue_text(maybe_break(kw_word[KW_HASH], 20));
            queue_token_end();
        end
        // data packets, controls mixed in
        repeat ($urandom_range(k == CC_PUT ? 1 : 0, 4)) begin
            int len;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                queue_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31))
                                                       : 8'($urandom_range(32, 255)),
                           i == len - 1);
            end
        end
        if ($urandom_range(0, 3) != 0)
            script_q.push_back(beat(CMD_CLOSE, 8'($urandom), 1'($urandom)));
    endfunction

    // Anything goes: stray bytes, opens, closes and the unused cmd code.
    function automatic void queue_noise();
        logic [1:0] c;
        repeat ($urandom_range(5, 30)) begin
            c = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : CMD_BYTE;
            script_q.push_back(beat(c, 8'($urandom), 1'($urandom_range(0, 3) == 0)));
        end
    endfunction

    initial begin : stimulus
        typedef struct {
            in_beat_t  stim;
            bit        typed;
            out_beat_t res;
        } plan_row_t;
        plan_row_t plan [$];
        out_beat_t silent;
        out_beat_t put_start;
        bit        paused_once;
        int        random_end;

        silent      = '0;
        put_start   = event_of(EV_START, CC_PUT);   // no filesize seen: size 0
        paused_once = 1'b0;

        // Directed table: reset state, unused code, closing phase, PUT of
        // size zero, control skipping, data byte extremes.
        plan = '{
            '{beat(CMD_BYTE, "A", 1'b1),   1'b1, event_of(EV_CLOSE_REQ, 3'd0)},
            '{beat(CMD_UNUSED, 8'hFF, 1'b1), 1'b1, silent},
            '{beat(CMD_CLOSE, 8'h00, 1'b0), 1'b1, silent},
            '{beat(CMD_OPEN, 8'h00, 1'b0),  1'b1, silent},
            '{beat(CMD_BYTE, "P", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, "U", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, "T", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, 8'h00, 1'b0), 1'b0, silent},
            '{beat(CMD_BYTE, 8'h1F, 1'b0), 1'b0, silent},
            '{beat(CMD_BYTE, "#", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, 8'h0A, 1'b0), 1'b1, put_start},
            '{beat(CMD_BYTE, "x", 1'b1),   1'b1, event_of(EV_PUT_DONE, 3'd0)},
            '{beat(CMD_BYTE, 8'hFF, 1'b1), 1'b1, silent},
            '{beat(CMD_CLOSE, 8'hFF, 1'b1), 1'b1, event_of(EV_CLOSE_FILE, 3'd0)},
            '{beat(CMD_OPEN, 8'hFF, 1'b1),  1'b1, silent},
            '{beat(CMD_BYTE, "X", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, 8'h0A, 1'b0), 1'b1, event_of(EV_CLOSE_REQ, 3'd0)},
            '{beat(CMD_BYTE, "Q", 1'b0),   1'b1, silent},
            '{beat(CMD_BYTE, "R", 1'b1),   1'b1, silent},
            '{beat(CMD_BYTE, 8'h80, 1'b1), 1'b1, event_of(EV_CLOSE_REQ, 3'd0)},
            '{beat(CMD_OPEN, 8'h00, 1'b0),  1'b1, silent},
            '{beat(CMD_BYTE, "G", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, "E", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, "T", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, 8'h0D, 1'b0), 1'b0, silent},
            '{beat(CMD_BYTE, "#", 1'b0),   1'b0, silent},
            '{beat(CMD_BYTE, 8'h0A, 1'b1), 1'b1, event_of(EV_START, CC_GET)},
            '{beat(CMD_CLOSE, 8'h00, 1'b0), 1'b1, event_of(EV_CLOSE_FILE, 3'd0)}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send_beat(plan[i].stim, plan[i].typed, plan[i].res);

        // Random sessions; idling modes change from one session to the next.
        random_end = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_end) begin
            if (beats_sent >= random_end - RANDOM_BEATS + QUIET_FROM) quiet_tail <= 1'b1;
            tx_gaps_on    = $urandom_range(0, 3) != 0;
            rx_stalls_on <= $urandom_range(0, 3) != 0;
            if ((!paused_once && beats_sent >= random_end - RANDOM_BEATS / 2)
                    || $urandom_range(0, 19) == 0) begin
                drain_results();
                paused_once = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) queue_noise();
            else queue_session();
            while (script_q.size() != 0) send_beat(script_q.pop_front(), 1'b0, silent);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tcpp_pkg.sv
rtl/tcpp_token.sv
rtl/tcpp_skid.sv
rtl/text_command_protocol_parser.sv
rtl/tcpp_checker.sv
bench/text_command_protocol_parser_tb.sv
